@@ rtl/anp_pkg.sv @@
// shared types and constants for the ascii number parser
`timescale 1ns / 1ps

package anp_pkg;

    localparam int VALUE_WIDTH  = 32;
    localparam int RESULT_WIDTH = 32;
    localparam int CHAR_WIDTH   = 8;

    localparam logic [CHAR_WIDTH-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_WIDTH-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_WIDTH-1:0] CH_LX    = 8'h78;

    typedef logic [VALUE_WIDTH-1:0] mag_t;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] char_code;
        logic                  unsigned_mode;
    } char_beat_t;

    typedef struct packed {
        logic [RESULT_WIDTH-1:0] value;
        logic                    valid_res;
    } result_beat_t;

    // handshake between the input register and the parse core
    typedef struct packed {
        logic valid;
        logic take;
    } stage_ctl_t;

endpackage

@@ rtl/anp_in_stage.sv @@
// input register for character beats
`timescale 1ns / 1ps

module anp_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    input  anp_pkg::char_beat_t char_beat,
    output logic                char_stall,
    input  logic                take,
    output logic                s1_valid,
    output anp_pkg::char_beat_t s1_beat
);
    import anp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    char_beat_t beat_reg;
    logic       load;

    assign load       = char_valid && !char_stall;
    assign char_stall = valid_reg && !take;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= char_beat;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_beat  = beat_reg;

endmodule

@@ rtl/anp_parse_core.sv @@
// per-string parse state and its next-state logic
`timescale 1ns / 1ps

module anp_parse_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  anp_pkg::stage_ctl_t   s1_ctl,
    input  anp_pkg::char_beat_t   s1_beat,
    output logic                  is_nul,
    output logic                  res_fire,
    output anp_pkg::result_beat_t res_beat
);
    import anp_pkg::*;

    localparam int WIDE_W = VALUE_WIDTH + 4;

    typedef enum logic [7:0] {
        PH_START   = 8'b0000_0001,
        PH_ZERO    = 8'b0000_0010,
        PH_SPACE   = 8'b0000_0100,
        PH_SIGN    = 8'b0000_1000,
        PH_DEC     = 8'b0001_0000,
        PH_HEXNEED = 8'b0010_0000,
        PH_HEX     = 8'b0100_0000,
        PH_TAIL    = 8'b1000_0000
    } phase_t;

    phase_t phase_reg, phase_next;
    logic   neg_reg, neg_next;
    mag_t   mag_reg, mag_next;
    logic   ovf_reg, ovf_next;
    logic   mode_reg, mode_next;

    logic [CHAR_WIDTH-1:0] c;
    logic                  fire;
    logic                  mode_eff;
    logic                  is_space;
    logic                  dec_ok;
    logic                  hex_ok;
    logic [3:0]            dec_val;
    logic [3:0]            hex_val;
    logic                  hex_ctx;
    logic [3:0]            digit;
    logic [WIDE_W-1:0]     wide;
    logic                  acc_ovf;
    mag_t                  acc_mag;
    logic                  acc_ovf_flag;
    mag_t                  fin;
    logic                  ok;

    assign c        = s1_beat.char_code;
    assign fire     = s1_ctl.valid && s1_ctl.take;
    assign is_nul   = (c == CH_NUL);
    assign mode_eff = (phase_reg == PH_START) ? s1_beat.unsigned_mode : mode_reg;

    // character classes
    always_comb
    begin
        is_space = c inside {[CH_TAB:CH_CR], CH_SPACE};
        dec_ok   = c inside {[CH_ZERO:CH_NINE]};
        dec_val  = 4'(c - CH_ZERO);
        hex_ok   = 1'b1;
        hex_val  = dec_val;
        if (c inside {[CH_LA:CH_LF]})
        begin
            hex_val = 4'(c - CH_LA + 8'd10);
        end
        else if (c inside {[CH_UA:CH_UF]})
        begin
            hex_val = 4'(c - CH_UA + 8'd10);
        end
        else if (!dec_ok)
        begin
            hex_ok = 1'b0;
        end
    end

    // shared multiply-add, base 16 or 10
    assign hex_ctx = (phase_reg == PH_HEXNEED) || (phase_reg == PH_HEX);
    assign digit   = hex_ctx ? hex_val : dec_val;

    always_comb
    begin
        if (hex_ctx)
        begin
            wide = ({4'b0, mag_reg} << 4) + WIDE_W'(digit);
        end
        else
        begin
            wide = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1) + WIDE_W'(digit);
        end
        acc_ovf = |wide[WIDE_W-1:VALUE_WIDTH];
        if (ovf_reg)
        begin
            acc_mag      = mag_reg;
            acc_ovf_flag = 1'b1;
        end
        else if (acc_ovf)
        begin
            acc_mag      = '1;
            acc_ovf_flag = 1'b1;
        end
        else
        begin
            acc_mag      = wide[VALUE_WIDTH-1:0];
            acc_ovf_flag = 1'b0;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        ovf_next   = ovf_reg;
        mode_next  = mode_reg;
        if (fire)
        begin
            mode_next = mode_eff;
            if (is_nul)
            begin
                phase_next = PH_START;
                neg_next   = 1'b0;
                mag_next   = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_START, PH_SPACE:
                    begin
                        if (is_space)
                        begin
                            phase_next = PH_SPACE;
                        end
                        else if (c == CH_PLUS || c == CH_MINUS)
                        begin
                            neg_next   = (c == CH_MINUS);
                            phase_next = PH_SIGN;
                        end
                        else if (phase_reg == PH_START && c == CH_ZERO)
                        begin
                            phase_next = PH_ZERO;
                        end
                        else if (dec_ok)
                        begin
                            mag_next   = acc_mag;
                            ovf_next   = acc_ovf_flag;
                            phase_next = PH_DEC;
                        end
                        else
                        begin
                            phase_next = PH_TAIL;
                        end
                    end
                    PH_ZERO, PH_SIGN, PH_DEC:
                    begin
                        if (phase_reg == PH_ZERO && c == CH_LX)
                        begin
                            phase_next = PH_HEXNEED;
                        end
                        else if (dec_ok)
                        begin
                            mag_next   = acc_mag;
                            ovf_next   = acc_ovf_flag;
                            phase_next = PH_DEC;
                        end
                        else
                        begin
                            phase_next = PH_TAIL;
                        end
                    end
                    PH_HEXNEED, PH_HEX:
                    begin
                        if (hex_ok)
                        begin
                            mag_next   = acc_mag;
                            ovf_next   = acc_ovf_flag;
                            phase_next = PH_HEX;
                        end
                        else
                        begin
                            phase_next = PH_TAIL;
                        end
                    end
                    PH_TAIL:
                    begin
                        phase_next = PH_TAIL;
                    end
                    default:
                    begin
                        phase_next = PH_START;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            ovf_reg   <= 1'b0;
            mode_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            ovf_reg   <= ovf_next;
            mode_reg  <= mode_next;
        end
    end

    // final value at the terminator
    always_comb
    begin
        if (mode_eff)
        begin
            if (ovf_reg)
            begin
                fin = '1;
            end
            else if (neg_reg)
            begin
                fin = '0 - mag_reg;
            end
            else
            begin
                fin = mag_reg;
            end
        end
        else if (neg_reg)
        begin
            if (ovf_reg || (mag_reg[VALUE_WIDTH-1] && |mag_reg[VALUE_WIDTH-2:0]))
            begin
                fin = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
            end
            else
            begin
                fin = '0 - mag_reg;
            end
        end
        else if (ovf_reg || mag_reg[VALUE_WIDTH-1])
        begin
            fin = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end
        else
        begin
            fin = mag_reg;
        end
    end

    assign ok = !(phase_reg == PH_SPACE || phase_reg == PH_SIGN ||
                  phase_reg == PH_HEXNEED || phase_reg == PH_TAIL);

    assign res_fire           = fire && is_nul;
    assign res_beat.value     = RESULT_WIDTH'(fin);
    assign res_beat.valid_res = ok;

endmodule

@@ rtl/anp_out_stage.sv @@
// result register for the output channel
`timescale 1ns / 1ps

module anp_out_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  anp_pkg::result_beat_t load_beat,
    output logic                  room,
    output logic                  result_valid,
    input  logic                  result_stall,
    output anp_pkg::result_beat_t result_beat
);
    import anp_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    result_beat_t beat_reg;

    assign room       = !valid_reg || !result_stall;
    assign valid_next = load ? 1'b1 : (room ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= load_beat;
        end
    end

    assign result_valid = valid_reg;
    assign result_beat  = beat_reg;

endmodule

@@ rtl/ascii_number_to_int32_parser.sv @@
// top level of the ascii number parser
//
//   channel   direction   handshake                    beat
//   char      in          char_valid / char_stall      char_beat_t
//   result    out         result_valid / result_stall  result_beat_t
//
// one character a cycle while not stalled; each is registered, then parsed
// a result shows in the cycle after its terminator is parsed
// rst_n clears the parse state and both stage valids at once
// a stalled result holds the next terminator in the input register and stalls
// the char channel; characters ahead of that terminator keep flowing
`timescale 1ns / 1ps

module ascii_number_to_int32_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_stall,
    input  anp_pkg::char_beat_t   char_beat,
    output logic                  result_valid,
    input  logic                  result_stall,
    output anp_pkg::result_beat_t result_beat
);
    import anp_pkg::*;

    logic         s1_valid;
    char_beat_t   s1_beat;
    stage_ctl_t   s1_ctl;
    logic         is_nul;
    logic         room;
    logic         res_fire;
    result_beat_t res_beat;

    assign s1_ctl.valid = s1_valid;
    assign s1_ctl.take  = s1_valid && (!is_nul || room);

    anp_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_beat  (char_beat),
        .char_stall (char_stall),
        .take       (s1_ctl.take),
        .s1_valid   (s1_valid),
        .s1_beat    (s1_beat)
    );

    anp_parse_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_ctl   (s1_ctl),
        .s1_beat  (s1_beat),
        .is_nul   (is_nul),
        .res_fire (res_fire),
        .res_beat (res_beat)
    );

    anp_out_stage u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (res_fire),
        .load_beat    (res_beat),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_beat  (result_beat)
    );

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |=> result_valid)
        else $error("parsed terminator did not reach the result register");

    a_stall_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> s1_valid && is_nul && result_valid && result_stall)
        else $error("input stalled without a blocked terminator");

    a_fire_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |-> s1_valid && s1_beat.char_code == CH_NUL && room)
        else $error("result fired without a terminator");

endmodule

@@ tb/tb_ascii_number_to_int32_parser.sv @@
// self-checking testbench for the ascii number parser, with its own parse predictor
`timescale 1ns / 1ps

module tb_ascii_number_to_int32_parser;

    import anp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RADIX_DEC   = 10;
    localparam int RADIX_HEX   = 16;
    localparam int RANDOM_CHARS = 1275;

    typedef enum logic [2:0] {
        SCAN_START,
        SCAN_ZERO,
        SCAN_BLANK,
        SCAN_SIGN,
        SCAN_DEC,
        SCAN_HEX_WAIT,
        SCAN_HEX,
        SCAN_JUNK
    } scan_t;

    typedef struct {
        char_beat_t beat;
        bit         hold;
    } char_job_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         char_valid = 1'b0;
    logic         char_stall;
    char_beat_t   char_beat = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_beat_t result_beat;

    char_job_t    char_jobs[$];
    result_beat_t pending_results[$];
    byte unsigned draft[$];
    bit           hold_next = 1'b0;
    string        hex_pool = "0123456789abcdefABCDEF";

    // parse state of the predictor
    scan_t        scan = SCAN_START;
    bit           neg_sign = 1'b0;
    bit           saturated = 1'b0;
    bit           unsigned_rules = 1'b0;
    bit           junk_seen = 1'b0;
    logic [63:0]  mag = '0;

    int           fail_count = 0;
    int           chars_sent = 0;
    int           strings_done = 0;
    int           results_seen = 0;
    int           cycle_count = 0;
    int           tx_wait = 0;
    bit           tx_burst = 1'b0;
    int           rx_wait = 0;
    bit           rx_burst = 1'b0;
    int           hold_cycles = 0;
    int           holds_done = 0;

    ascii_number_to_int32_parser u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_beat    (char_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_beat  (result_beat)
    );

    always #2 clk = ~clk;

    task automatic take_digit(input logic [7:0] c, input int radix, input scan_t next);
        int d;
        logic [63:0] nxt;
        d = -1;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = c - CH_ZERO;
        else if (c >= CH_LA && c <= CH_LF)
            d = c - CH_LA + 10;
        else if (c >= CH_UA && c <= CH_UF)
            d = c - CH_UA + 10;
        if (d >= radix)
            d = -1;
        if (d >= 0)
        begin
            if (!saturated)
            begin
                nxt = mag * radix + d;
                if (nxt > 64'hFFFF_FFFF)
                begin
                    saturated = 1'b1;
                    mag = 64'hFFFF_FFFF;
                end
                else
                begin
                    mag = nxt;
                end
            end
            scan = next;
        end
        else
        begin
            junk_seen = 1'b1;
            scan = SCAN_JUNK;
        end
    endtask

    task automatic parse_char(input char_beat_t b);
        logic [7:0]   c;
        logic [31:0]  word;
        result_beat_t res;
        c = b.char_code;
        if (scan == SCAN_START)
            unsigned_rules = b.unsigned_mode;
        if (c == CH_NUL)
        begin
            if (unsigned_rules)
                word = saturated ? 32'hFFFF_FFFF : (neg_sign ? -mag[31:0] : mag[31:0]);
            else if (neg_sign)
                word = (saturated || mag > 64'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
            else
                word = (saturated || mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
            res.value = word;
            res.valid_res = !junk_seen && scan != SCAN_BLANK && scan != SCAN_SIGN
                            && scan != SCAN_HEX_WAIT;
            pending_results.push_back(res);
            strings_done++;
            scan = SCAN_START;
            neg_sign = 1'b0;
            saturated = 1'b0;
            junk_seen = 1'b0;
            mag = '0;
        end
        else
        begin
            case (scan)
                SCAN_START, SCAN_BLANK:
                begin
                    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                    begin
                        scan = SCAN_BLANK;
                    end
                    else if (c == CH_PLUS || c == CH_MINUS)
                    begin
                        neg_sign = (c == CH_MINUS);
                        scan = SCAN_SIGN;
                    end
                    else if (scan == SCAN_START && c == CH_ZERO)
                    begin
                        scan = SCAN_ZERO;
                    end
                    else
                    begin
                        take_digit(c, RADIX_DEC, SCAN_DEC);
                    end
                end
                SCAN_ZERO:
                begin
                    if (c == CH_LX)
                        scan = SCAN_HEX_WAIT;
                    else
                        take_digit(c, RADIX_DEC, SCAN_DEC);
                end
                SCAN_SIGN, SCAN_DEC:
                    take_digit(c, RADIX_DEC, SCAN_DEC);
                SCAN_HEX_WAIT, SCAN_HEX:
                    take_digit(c, RADIX_HEX, SCAN_HEX);
                default:
                    scan = SCAN_JUNK;
            endcase
        end
    endtask

    task automatic add_char(input logic [7:0] c, input bit m);
        char_job_t job;
        job.beat.char_code = c;
        job.beat.unsigned_mode = m;
        job.hold = hold_next;
        hold_next = 1'b0;
        char_jobs.push_back(job);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            draft.push_back(s[i]);
    endtask

    // draft plus terminator; random mode bits on every character when asked
    task automatic add_string(input bit rand_mode, input bit m);
        foreach (draft[i])
            add_char(draft[i], rand_mode ? 1'($urandom_range(0, 1)) : m);
        add_char(CH_NUL, rand_mode ? 1'($urandom_range(0, 1)) : m);
        draft.delete();
    endtask

    task automatic add_text(input string s, input bit m);
        put_text(s);
        add_string(1'b0, m);
    endtask

    task automatic add_random_string();
        int pick;
        int n;
        int ws;
        longint unsigned num;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++)
            begin
                ws = $urandom_range(0, 5);
                draft.push_back(ws == 5 ? CH_SPACE : CH_TAB + ws[7:0]);
            end
            case ($urandom_range(0, 3))
                0: draft.push_back(CH_PLUS);
                1: draft.push_back(CH_MINUS);
                default: ;
            endcase
            if ($urandom_range(0, 7) == 0)
                draft.push_back(CH_ZERO);
            case ($urandom_range(0, 4))
                0: num = $urandom_range(0, 999);
                1: num = $urandom;
                2: num = 64'd2147483645 + $urandom_range(0, 4);
                3: num = 64'd4294967293 + $urandom_range(0, 4);
                default: num = {$urandom, $urandom};
            endcase
            put_text($sformatf("%0d", num));
        end
        else if (pick < 70)
        begin
            draft.push_back(CH_ZERO);
            draft.push_back(CH_LX);
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
                draft.push_back(hex_pool[$urandom_range(0, 21)]);
        end
        else if (pick < 80)
        begin
            put_text($sformatf("%0d", $urandom_range(0, 9999)));
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                draft.push_back(8'($urandom_range(1, 255)));
        end
        else if (pick < 90)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                draft.push_back(8'($urandom_range(1, 255)));
        end
        else if (pick < 95)
        begin
            case ($urandom_range(0, 3))
                0: draft.push_back(CH_SPACE);
                1: draft.push_back(CH_MINUS);
                2: put_text("0x");
                default:
                begin
                    draft.push_back(CH_ZERO);
                    draft.push_back(8'($urandom_range(1, 255)));
                end
            endcase
        end
        add_string(1'b1, 1'b0);
    endtask

    // character driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_beat <= '0;
            tx_wait = 0;
        end
        else
        begin
            if (char_valid && !char_stall)
            begin
                parse_char(char_beat);
                chars_sent++;
                tx_wait = tx_burst ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 63) == 0)
                    tx_burst = !tx_burst;
            end
            if (!char_valid || !char_stall)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    char_valid <= 1'b0;
                end
                else if (char_jobs.size() > 0
                         && !(char_jobs[0].hold && pending_results.size() > 0))
                begin
                    char_beat <= char_jobs[0].beat;
                    char_valid <= 1'b1;
                    void'(char_jobs.pop_front());
                end
                else
                begin
                    char_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin
        result_beat_t want;
        bit           stall_d;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result beat: value %h valid_res %b",
                           result_beat.value, result_beat.valid_res);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result_beat.value !== want.value)
                    begin
                        $error("value: expected %h, got %h", want.value, result_beat.value);
                        fail_count++;
                    end
                    if (result_beat.valid_res !== want.valid_res)
                    begin
                        $error("valid_res: expected %b, got %b",
                               want.valid_res, result_beat.valid_res);
                        fail_count++;
                    end
                end
                rx_wait = rx_burst ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 15) == 0)
                    rx_burst = !rx_burst;
            end
            // long hold-offs let the parser back up into the character channel
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                stall_d = 1'b1;
            end
            else if ((holds_done == 0 && results_seen >= 40)
                     || (holds_done == 1 && results_seen >= 100))
            begin
                hold_cycles = 300;
                holds_done++;
                stall_d = 1'b1;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                stall_d = 1'b1;
            end
            else
            begin
                stall_d = 1'b0;
            end
            result_stall <= stall_d;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int base_len;
        add_text("", 1'b0);
        add_text("0", 1'b0);
        add_text("2147483647", 1'b0);
        add_text("-2147483648", 1'b0);
        add_text("2147483648", 1'b0);
        add_text("-99999999999", 1'b0);
        add_text("4294967295", 1'b1);
        add_text("4294967296", 1'b1);
        add_text("-1", 1'b1);
        add_text("-4294967296", 1'b1);
        add_text("0xFFFFFFFF", 1'b0);
        add_text("0xdeadBEEF", 1'b1);
        add_text("0x100000000", 1'b1);
        add_text("0x", 1'b0);
        add_text("\t\n\013\014\r +42", 1'b0);
        add_text("   ", 1'b0);
        add_text("-", 1'b1);
        add_text("12a34", 1'b0);
        add_text("0X1F", 1'b0);
        add_text("-0x10", 1'b0);
        add_text("007", 1'b1);
        add_text("0xA@g/", 1'b0);
        add_text("9:", 1'b1);
        draft.push_back(8'h35);
        draft.push_back(8'hff);
        add_string(1'b0, 1'b0);
        draft.push_back(8'h80);
        add_string(1'b0, 1'b1);
        hold_next = 1'b1;
        base_len = char_jobs.size();
        while (char_jobs.size() < base_len + RANDOM_CHARS)
        begin
            if ($urandom_range(0, 29) == 0)
                hold_next = 1'b1;
            add_random_string();
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (char_jobs.size() != 0 || char_valid)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("sent %0d characters in %0d strings, checked %0d results", chars_sent,
                 strings_done, results_seen);
        $display("signed and unsigned rules, decimal and hex, random gaps and long stalls");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/anp_pkg.sv
rtl/anp_in_stage.sv
rtl/anp_parse_core.sv
rtl/anp_out_stage.sv
rtl/ascii_number_to_int32_parser.sv
tb/tb_ascii_number_to_int32_parser.sv
